/* hdl/obgl_pkg.sv */
// Shared types and constants for the overlap box grouping block.
package obgl_pkg;

    localparam int POS_W         = 12;
    localparam int DIM_W         = 13;
    localparam int END_W         = DIM_W + 1;
    localparam int AREA_W        = 2 * DIM_W;
    localparam int DIM_FIELD_MAX = (1 << DIM_W) - 1;
    localparam int MAX_DIM_DEF   = 4096;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] top;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } box_t;

    typedef struct packed {
        box_t box;
        logic run_final;
    } res_t;

endpackage

/* hdl/overlap_box_group_largest.sv */
// Overlap box grouping: keeps the largest box of each group of overlapping boxes.
//
// Usage:
//   Boxes enter on the input channel (in_valid / in_ready) with box_left, box_top,
//   box_width, box_height and end_of_list. A box joins the open group when twice its
//   intersection with the group's first box exceeds either box's area; otherwise the
//   group closes and the box starts a new one. Each closed group yields its largest box
//   on the output channel (out_valid / out_ready). end_of_list flushes the open group,
//   so one box can give up to two results; run_final marks the last of them.
//   Widths or heights above MAX_DIM are saturated to MAX_DIM on entry.
//   The request that closes a group is held in the input register; its result is then queued.
//   Throughput: one box per cycle, set by the combinational update of the group state
//   from the input register; a four-entry result queue takes up to two results a cycle
//   and the input stage advances only while two entries are free.
//   When the receiver stalls, the queue fills and in_ready drops; nothing is lost.
//   Reset empties the queue and the input register and leaves no group open.
module overlap_box_group_largest
    import obgl_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [POS_W-1:0] box_left,
    input  logic [POS_W-1:0] box_top,
    input  logic [DIM_W-1:0] box_width,
    input  logic [DIM_W-1:0] box_height,
    input  logic             end_of_list,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] best_left,
    output logic [POS_W-1:0] best_top,
    output logic [DIM_W-1:0] best_width,
    output logic [DIM_W-1:0] best_height,
    output logic             run_final
);

    localparam int DIM_CAP_I = (MAX_DIM > DIM_FIELD_MAX) ? DIM_FIELD_MAX : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_I);

    // input register
    logic              in_valid_reg;
    box_t              in_box_reg;
    logic [AREA_W-1:0] in_area_reg;
    logic              in_last_reg;

    // group state
    logic              open_reg, open_next;
    box_t              anchor_reg, anchor_next;
    logic [AREA_W-1:0] anchor_area_reg, anchor_area_next;
    box_t              best_reg, best_next;
    logic [AREA_W-1:0] best_area_reg, best_area_next;

    // result queue
    res_t              queue_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QCNT_W-1:0] count_reg;

    box_t              clamped;
    logic              accept_in, fire, pop;
    logic [END_W-1:0]  a_end_x, b_end_x, a_end_y, b_end_y;
    logic [END_W-1:0]  lo_x, hi_x, lo_y, hi_y;
    logic [DIM_W-1:0]  iw, ih;
    logic [AREA_W-1:0] inter;
    logic [AREA_W:0]   inter2;
    logic              join_grp, split;
    res_t              split_res, last_res, res0, res1;
    logic [1:0]        push_cnt;

    // Saturate oversized dimensions on entry.
    always_comb
    begin
        clamped.left   = box_left;
        clamped.top    = box_top;
        clamped.width  = (box_width > DIM_CAP) ? DIM_CAP : box_width;
        clamped.height = (box_height > DIM_CAP) ? DIM_CAP : box_height;
    end

    assign fire      = in_valid_reg && (count_reg <= QCNT_W'(QDEPTH - 2));
    assign in_ready  = !in_valid_reg || fire;
    assign accept_in = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_box_reg  <= clamped;
            in_area_reg <= AREA_W'(clamped.width) * AREA_W'(clamped.height);
            in_last_reg <= end_of_list;
        end
    end

    // Intersection of the held box with the anchor.
    always_comb
    begin
        a_end_x = END_W'(anchor_reg.left) + END_W'(anchor_reg.width);
        b_end_x = END_W'(in_box_reg.left) + END_W'(in_box_reg.width);
        a_end_y = END_W'(anchor_reg.top) + END_W'(anchor_reg.height);
        b_end_y = END_W'(in_box_reg.top) + END_W'(in_box_reg.height);
        lo_x = (anchor_reg.left > in_box_reg.left) ? END_W'(anchor_reg.left)
                                                   : END_W'(in_box_reg.left);
        lo_y = (anchor_reg.top > in_box_reg.top) ? END_W'(anchor_reg.top)
                                                 : END_W'(in_box_reg.top);
        hi_x = (a_end_x < b_end_x) ? a_end_x : b_end_x;
        hi_y = (a_end_y < b_end_y) ? a_end_y : b_end_y;
        iw = (hi_x > lo_x) ? DIM_W'(hi_x - lo_x) : '0;
        ih = (hi_y > lo_y) ? DIM_W'(hi_y - lo_y) : '0;
        inter  = AREA_W'(iw) * AREA_W'(ih);
        inter2 = {inter, 1'b0};
        join_grp = (inter2 > {1'b0, in_area_reg}) || (inter2 > {1'b0, anchor_area_reg});
    end

    // Group state update and results for the held box.
    always_comb
    begin
        open_next        = open_reg;
        anchor_next      = anchor_reg;
        anchor_area_next = anchor_area_reg;
        best_next        = best_reg;
        best_area_next   = best_area_reg;
        split            = 1'b0;

        if (!open_reg || !join_grp)
        begin
            split            = open_reg;
            open_next        = 1'b1;
            anchor_next      = in_box_reg;
            anchor_area_next = in_area_reg;
            if (in_area_reg != '0)
            begin
                best_next      = in_box_reg;
                best_area_next = in_area_reg;
            end
            else
            begin
                best_next      = '0;
                best_area_next = '0;
            end
        end
        else if (in_area_reg > best_area_reg)
        begin
            best_next      = in_box_reg;
            best_area_next = in_area_reg;
        end

        if (in_last_reg)
        begin
            open_next = 1'b0;
        end

        split_res.box       = best_reg;
        split_res.run_final = !in_last_reg;
        last_res.box        = best_next;
        last_res.run_final  = 1'b1;
        res0     = split ? split_res : last_res;
        res1     = last_res;
        push_cnt = {1'b0, split} + {1'b0, in_last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg        <= 1'b0;
            anchor_reg      <= '0;
            anchor_area_reg <= '0;
            best_reg        <= '0;
            best_area_reg   <= '0;
        end
        else if (fire)
        begin
            open_reg        <= open_next;
            anchor_reg      <= anchor_next;
            anchor_area_reg <= anchor_area_next;
            best_reg        <= best_next;
            best_area_reg   <= best_area_next;
        end
    end

    // Result queue: up to two pushes and one pop per cycle.
    always_ff @(posedge clk)
    begin
        if (fire && push_cnt != 2'd0)
        begin
            queue_reg[tail_reg] <= res0;
        end
        if (fire && push_cnt == 2'd2)
        begin
            queue_reg[tail_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                tail_reg <= tail_reg + QPTR_W'(push_cnt);
            end
            if (pop)
            begin
                head_reg <= head_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (fire ? QCNT_W'(push_cnt) : '0) - QCNT_W'(pop);
        end
    end

    assign out_valid   = (count_reg != '0);
    assign best_left   = queue_reg[head_reg].box.left;
    assign best_top    = queue_reg[head_reg].box.top;
    assign best_width  = queue_reg[head_reg].box.width;
    assign best_height = queue_reg[head_reg].box.height;
    assign run_final   = queue_reg[head_reg].run_final;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_final |-> count_reg >= QCNT_W'(2))
        else $error("non-final result without its pair queued");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> !open_reg)
        else $error("group left open after end of list");
`endif

endmodule

/* tb/overlap_box_group_largest_test.sv */
// Self-checking testbench for the overlap box grouping block with a built-in group predictor.
`timescale 1ns / 1ps

module overlap_box_group_largest_test;
    import obgl_pkg::*;

    localparam int DIM_CAP     = MAX_DIM_DEF;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_AT     = 160;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int PRESS_START = 150;
    localparam int PRESS_LEN   = 60;
    localparam int RAND_TOTAL  = 420;

    typedef struct {
        box_t        raw;
        logic        last;
        int unsigned gap;
        bit          drain_first;
    } box_request_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [POS_W-1:0] box_left = '0;
    logic [POS_W-1:0] box_top = '0;
    logic [DIM_W-1:0] box_width = '0;
    logic [DIM_W-1:0] box_height = '0;
    logic             end_of_list = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [POS_W-1:0] best_left;
    logic [POS_W-1:0] best_top;
    logic [DIM_W-1:0] best_width;
    logic [DIM_W-1:0] best_height;
    logic             run_final;

    overlap_box_group_largest i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .end_of_list (end_of_list),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .best_left   (best_left),
        .best_top    (best_top),
        .best_width  (best_width),
        .best_height (best_height),
        .run_final   (run_final)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted group state
    logic              grp_open;
    box_t              grp_anchor;
    box_t              grp_lead;
    logic [AREA_W-1:0] grp_lead_area;

    box_request_t pending_boxes[$];
    res_t         expected_best[$];
    box_request_t next_req;
    res_t         want;

    int unsigned boxes_accepted = 0;
    int unsigned total_boxes    = 0;
    int unsigned wait_count     = 0;
    int unsigned results_seen   = 0;
    int unsigned stall_left     = 0;
    int unsigned stall_draw     = 0;
    int unsigned hold_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned check_errors   = 0;
    bit          hold_done      = 1'b0;
    bit          hold_active;
    bit          calm_send      = 1'b0;
    bit          drain_mark     = 1'b0;
    bit          press_done     = 1'b0;

    function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] d);
        return (d > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : d;
    endfunction

    function automatic logic [AREA_W-1:0] box_area(box_t b);
        return AREA_W'(b.width) * AREA_W'(b.height);
    endfunction

    function automatic logic [END_W-1:0] span_overlap(logic [POS_W-1:0] a0,
                                                      logic [DIM_W-1:0] alen,
                                                      logic [POS_W-1:0] b0,
                                                      logic [DIM_W-1:0] blen);
        logic [END_W-1:0] lo;
        logic [END_W-1:0] hi;
        logic [END_W-1:0] a_end;
        logic [END_W-1:0] b_end;
        lo    = (a0 > b0) ? END_W'(a0) : END_W'(b0);
        a_end = END_W'(a0) + END_W'(alen);
        b_end = END_W'(b0) + END_W'(blen);
        hi    = (a_end < b_end) ? a_end : b_end;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    task automatic open_group(box_t b);
        logic [AREA_W-1:0] a;
        a = box_area(b);
        grp_open   = 1'b1;
        grp_anchor = b;
        if (a != 0)
        begin
            grp_lead      = b;
            grp_lead_area = a;
        end
        else
        begin
            grp_lead      = '0;
            grp_lead_area = '0;
        end
    endtask

    task automatic group_largest_predict(box_t raw, logic last);
        box_t              b;
        logic [END_W-1:0]  iw;
        logic [END_W-1:0]  ih;
        logic [AREA_W+1:0] twice_inter;
        logic [AREA_W-1:0] a_new;
        logic [AREA_W-1:0] a_anc;
        res_t              r;
        b        = raw;
        b.width  = sat_dim(raw.width);
        b.height = sat_dim(raw.height);
        if (!grp_open)
        begin
            open_group(b);
        end
        else
        begin
            iw          = span_overlap(grp_anchor.left, grp_anchor.width, b.left, b.width);
            ih          = span_overlap(grp_anchor.top, grp_anchor.height, b.top, b.height);
            twice_inter = (AREA_W+2)'(2) * (AREA_W+2)'(iw) * (AREA_W+2)'(ih);
            a_new       = box_area(b);
            a_anc       = box_area(grp_anchor);
            if (twice_inter > (AREA_W+2)'(a_new) || twice_inter > (AREA_W+2)'(a_anc))
            begin
                // strict compare keeps the earlier box on a tie
                if (a_new > grp_lead_area)
                begin
                    grp_lead      = b;
                    grp_lead_area = a_new;
                end
            end
            else
            begin
                r.box       = grp_lead;
                r.run_final = !last;
                expected_best = {expected_best, r};
                open_group(b);
            end
        end
        if (last)
        begin
            r.box       = grp_lead;
            r.run_final = 1'b1;
            expected_best = {expected_best, r};
            grp_open = 1'b0;
        end
    endtask

    task automatic push_box(int l, int t, int w, int h, bit eol);
        box_request_t req;
        if (l < 0) l = 0;
        if (l > 4095) l = 4095;
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        if (w < 0) w = 0;
        if (w > DIM_FIELD_MAX) w = DIM_FIELD_MAX;
        if (h < 0) h = 0;
        if (h > DIM_FIELD_MAX) h = DIM_FIELD_MAX;
        req.raw.left    = POS_W'(l);
        req.raw.top     = POS_W'(t);
        req.raw.width   = DIM_W'(w);
        req.raw.height  = DIM_W'(h);
        req.last        = eol;
        req.gap         = calm_send ? 0 : $urandom_range(0, 14);
        req.drain_first = drain_mark;
        drain_mark      = 1'b0;
        pending_boxes   = {pending_boxes, req};
    endtask

    // Build a run of overlapping boxes around one anchor, then maybe close the list.
    task automatic push_group();
        int l, t, w, h, n, dw, dh, nl, nt, nw, nh;
        bit eol;
        l = $urandom_range(0, 4095);
        t = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(1, DIM_FIELD_MAX);
            h = $urandom_range(1, DIM_FIELD_MAX);
        end
        else
        begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
        end
        n = $urandom_range(1, 6);
        eol = ($urandom_range(0, 2) == 0);
        push_box(l, t, w, h, eol && (n == 1));
        dw = w / 8 + 1;
        dh = h / 8 + 1;
        for (int k = 1; k < n; k++)
        begin
            nl = l + $urandom_range(0, 2 * dw) - dw;
            nt = t + $urandom_range(0, 2 * dh) - dh;
            if ($urandom_range(0, 3) == 0)
            begin
                nw = w;
                nh = h;
            end
            else
            begin
                nw = w + $urandom_range(0, 2 * dw) - dw;
                nh = h + $urandom_range(0, 2 * dh) - dh;
            end
            if ($urandom_range(0, 11) == 0) nh = 0;
            push_box(nl, nt, nw, nh, eol && (k == n - 1));
        end
    endtask

    // Receiver hold-off, counted here and seen by the monitor
    assign hold_active = (boxes_accepted >= HOLD_AT) && !hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_active)
        begin
            if (hold_count == HOLD_LEN)
                hold_done <= 1'b1;
            else
                hold_count <= hold_count + 1;
        end
    end

    // Driver: present queued requests, run the predictor on each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            box_left      <= '0;
            box_top       <= '0;
            box_width     <= '0;
            box_height    <= '0;
            end_of_list   <= 1'b0;
            wait_count    <= 0;
            grp_open      = 1'b0;
            grp_anchor    = '0;
            grp_lead      = '0;
            grp_lead_area = '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                group_largest_predict({box_left, box_top, box_width, box_height}, end_of_list);
                boxes_accepted <= boxes_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_boxes.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_boxes[0].drain_first && expected_best.size() != 0)
                    in_valid <= 1'b0;
                else if (wait_count < pending_boxes[0].gap)
                begin
                    wait_count <= wait_count + 1;
                    in_valid   <= 1'b0;
                end
                else
                begin
                    next_req    = pending_boxes.pop_front();
                    box_left    <= next_req.raw.left;
                    box_top     <= next_req.raw.top;
                    box_width   <= next_req.raw.width;
                    box_height  <= next_req.raw.height;
                    end_of_list <= next_req.last;
                    in_valid    <= 1'b1;
                    wait_count  <= 0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest predicted group result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_best.size() == 0)
            begin
                check_errors++;
                if (check_errors <= 10)
                    $display("ERROR: unexpected result %0d %0d %0d %0d final %0b",
                             best_left, best_top, best_width, best_height, run_final);
            end
            else
            begin
                want = expected_best.pop_front();
                if (best_left !== want.box.left || best_top !== want.box.top ||
                    best_width !== want.box.width || best_height !== want.box.height ||
                    run_final !== want.run_final)
                begin
                    check_errors++;
                    if (check_errors <= 10)
                        $display("ERROR: exp %0d %0d %0d %0d/%0b got %0d %0d %0d %0d/%0b",
                                 want.box.left, want.box.top, want.box.width, want.box.height,
                                 want.run_final, best_left, best_top, best_width, best_height,
                                 run_final);
                end
            end
            // every fourth block of sixteen results runs without stalls
            stall_draw = ((results_seen % 64) >= 48) ? 0 : $urandom_range(0, 14);
            stall_left <= stall_draw;
            out_ready  <= (stall_draw == 0) && !hold_active;
        end
        else if (hold_active)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("overlap_box_group_largest verification failed");
        $finish;
    end

    initial
    begin
        // largest box, saturated on both axes, flushed alone
        push_box(4095, 4095, DIM_FIELD_MAX, DIM_FIELD_MAX, 1'b1);
        // zero-area anchor, then a growing group with a tie, then split plus flush
        push_box(0, 0, 0, 0, 1'b0);
        push_box(0, 0, 10, 10, 1'b0);
        push_box(1, 1, 10, 10, 1'b0);
        push_box(0, 0, 12, 12, 1'b0);
        push_box(2, 0, 12, 12, 1'b0);
        push_box(100, 100, 5, 5, 1'b1);
        // zero-area boxes only, each starting a group of its own
        push_box(5, 5, 0, 7, 1'b0);
        push_box(5, 5, 9, 0, 1'b1);
        // full-size boxes that barely touch
        push_box(0, 0, 4096, 4096, 1'b0);
        push_box(4095, 4095, 4096, 4096, 1'b0);
        push_box(0, 0, 0, 0, 1'b1);
        // exactly half overlap does not join, then a join ends the list
        push_box(0, 0, 10, 10, 1'b0);
        push_box(5, 0, 10, 10, 1'b0);
        push_box(6, 0, 10, 10, 1'b1);
        // disjoint boxes, oversize-by-one box joining a small anchor, small box inside that anchor
        push_box(2000, 2000, 50, 50, 1'b0);
        push_box(10, 3000, 50, 50, 1'b0);
        push_box(10, 3000, 4097, 4097, 1'b0);
        push_box(11, 3001, 1, 1, 1'b0);
        push_box(3000, 10, 8191, 1, 1'b1);
        push_box(4095, 0, 1, 4096, 1'b1);

        drain_mark = 1'b1;
        while (pending_boxes.size() < RAND_TOTAL)
        begin
            if (!press_done && pending_boxes.size() >= PRESS_START)
            begin
                // back-to-back disjoint boxes while the receiver holds off
                press_done = 1'b1;
                calm_send  = 1'b1;
                for (int k = 0; k < PRESS_LEN; k++)
                    push_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(1, 8), $urandom_range(1, 8), 1'b0);
                calm_send  = 1'b0;
                drain_mark = 1'b1;
            end
            else
            begin
                calm_send = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 9))
                    7, 8:
                        push_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, DIM_FIELD_MAX),
                                 $urandom_range(0, DIM_FIELD_MAX), $urandom_range(0, 3) == 0);
                    9:
                    begin
                        push_group();
                        push_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 30), $urandom_range(0, 30), 1'b1);
                    end
                    default:
                        push_group();
                endcase
            end
        end
        calm_send = 1'b0;
        push_box(1, 2, 3, 4, 1'b1);
        total_boxes = pending_boxes.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (boxes_accepted < total_boxes)
            @(posedge clk);
        while (expected_best.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (check_errors == 0 && expected_best.size() == 0)
            $display("overlap_box_group_largest verification clean");
        else
            $display("overlap_box_group_largest verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/obgl_pkg.sv
hdl/overlap_box_group_largest.sv
tb/overlap_box_group_largest_test.sv
